// ----- hdl/ut2t_pkg.sv -----
package ut2t_pkg;

  localparam int TS_W     = 32;
  localparam int DVS_W    = 18;
  localparam int LINE_LEN = 24;
  localparam int IDX_W    = $clog2(LINE_LEN);

  // divisors of the conversion steps
  localparam logic [DVS_W-1:0] DV_MINUTE = 18'd60;
  localparam logic [DVS_W-1:0] DV_HOUR   = 18'd60;
  localparam logic [DVS_W-1:0] DV_DAY    = 18'd24;
  localparam logic [DVS_W-1:0] DV_CENT   = 18'd146097;
  localparam logic [DVS_W-1:0] DV_YEAR   = 18'd7305;
  localparam logic [DVS_W-1:0] DV_MONTH  = 18'd30601;
  localparam logic [DVS_W-1:0] DV_MILLE  = 18'd1000;
  localparam logic [DVS_W-1:0] DV_DEC    = 18'd10;

  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_SEC,
    OP_MIN,
    OP_HR,
    OP_A,
    OP_C,
    OP_E,
    OP_G,
    OP_Y0,
    OP_Y1,
    OP_Y2,
    OP_Y3
  } op_t;

  typedef struct packed {
    logic             start;
    logic [TS_W-1:0]  dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TS_W-1:0]  quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // tens digit of a value below 100
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) begin
        t = 4'(k);
      end
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] tt;
    tt = {3'b000, tens_of(v)} * 7'd10;
    return 4'(v - tt);
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return CH_ZERO + {4'b0000, d};
  endfunction

endpackage

// ----- hdl/unix_time_to_utc_text.sv -----
// a changed sample is popped from the queue, then converted by eleven divisions by constants
//   on one reciprocal-multiply unit, then emitted one character a cycle while pop stays high,
//   24 words per line; repeated samples are dropped at the front
// reset: synchronous active-low rst_n clears the stored sample to 0, the queue and the sequencer
module unix_time_to_utc_text #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [ut2t_pkg::TS_W-1:0] in_timestamp,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                out_character,
  output logic                      out_last_char
);
  import ut2t_pkg::*;

  logic               q_full;
  logic               q_push;
  logic [TS_W-1:0]    q_wdata;
  logic               q_pop;
  logic [TS_W-1:0]    q_rdata;
  logic               q_empty;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  ut2t_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_timestamp (in_timestamp),
    .full         (full),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  ut2t_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  ut2t_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ut2t_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .empty         (empty),
    .pop           (pop),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

endmodule

// ----- hdl/ut2t_front.sv -----
module ut2t_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [ut2t_pkg::TS_W-1:0] in_timestamp,
  output logic                      full,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [ut2t_pkg::TS_W-1:0] q_data
);
  import ut2t_pkg::*;

  logic [TS_W-1:0] prev_r;
  logic            accept;

  assign accept = push && !q_full;
  assign full   = q_full;
  // a repeated sample is dropped here and never reaches the queue
  assign q_push = accept && (in_timestamp != prev_r);
  assign q_data = in_timestamp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (q_push) begin
      prev_r <= in_timestamp;
    end
  end

endmodule

// ----- hdl/ut2t_fifo.sv -----
module ut2t_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [ut2t_pkg::TS_W-1:0] wr_data,
  output logic                      full,
  input  logic                      rd_en,
  output logic [ut2t_pkg::TS_W-1:0] rd_data,
  output logic                      empty
);
  import ut2t_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  logic [TS_W-1:0]    mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W_Q-1:0] count_r;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count_r == CNT_W_Q'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/ut2t_div.sv -----
module ut2t_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ut2t_pkg::div_req_t  req,
  output ut2t_pkg::div_rsp_t  rsp
);
  import ut2t_pkg::*;

  logic [2:0]        stage_r;
  logic              done_r;
  logic [TS_W-1:0]   num_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [TS_W-1:0]   opd_r;
  logic [TS_W-1:0]   mag_r;
  logic [5:0]        shf_r;
  logic [2*TS_W-1:0] prod_r;
  logic [TS_W-1:0]   quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [1:0]        pre_sel;
  logic [TS_W-1:0]   mag_sel;
  logic [5:0]        shf_sel;

  // strip the power of two of the divisor, then multiply by a rounded-up
  // reciprocal of the odd part; exact over the dividend ranges issued
  // (full 32 bits for 60, 24 and 10, below 2^26 for 7305, below 2^21 for the others)
  always_comb begin
    case (req.divisor)
      // hours share the minute divisor
      DV_MINUTE: begin
        pre_sel = 2'd2;
        mag_sel = 32'd1145324613;
        shf_sel = 6'd34;
      end
      DV_DAY: begin
        pre_sel = 2'd3;
        mag_sel = 32'd1431655766;
        shf_sel = 6'd32;
      end
      DV_CENT: begin
        pre_sel = 2'd0;
        mag_sel = 32'd940738;
        shf_sel = 6'd37;
      end
      DV_YEAR: begin
        pre_sel = 2'd0;
        mag_sel = 32'd75257470;
        shf_sel = 6'd39;
      end
      DV_MONTH: begin
        pre_sel = 2'd0;
        mag_sel = 32'd1122831;
        shf_sel = 6'd35;
      end
      DV_MILLE: begin
        pre_sel = 2'd3;
        mag_sel = 32'd4195;
        shf_sel = 6'd19;
      end
      default: begin
        pre_sel = 2'd1;
        mag_sel = 32'd3435973837;
        shf_sel = 6'd34;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= {stage_r[1:0], req.start};
      done_r  <= stage_r[2];
    end
  end

  // multiply, shift, then remainder from the quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      dvs_r <= req.divisor;
      opd_r <= req.dividend >> pre_sel;
      mag_r <= mag_sel;
      shf_r <= shf_sel;
    end
    if (stage_r[0]) begin
      prod_r <= {{TS_W{1'b0}}, opd_r} * {{TS_W{1'b0}}, mag_r};
    end
    if (stage_r[1]) begin
      quo_r <= TS_W'(prod_r >> shf_r);
    end
    if (stage_r[2]) begin
      rem_r <= DVS_W'(num_r - quo_r * TS_W'(dvs_r));
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- hdl/ut2t_back.sv -----
module ut2t_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  logic [ut2t_pkg::TS_W-1:0] q_data,
  output logic                      q_pop,
  output ut2t_pkg::div_req_t        div_req,
  input  ut2t_pkg::div_rsp_t        div_rsp,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                out_character,
  output logic                      out_last_char
);
  import ut2t_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_LEN - 1);

  state_t           state_r;
  state_t           state_nxt;
  op_t              op_r;
  logic [IDX_W-1:0] idx_r;
  logic [TS_W-1:0]  num_r;
  logic [15:0]      days_r;
  logic [21:0]      b_r;
  logic [12:0]      c_r;
  logic [9:0]       d_r;
  logic [4:0]       e_r;
  logic [5:0]       sec_r;
  logic [5:0]       min_r;
  logic [4:0]       hr_r;
  logic [3:0]       mon_r;
  logic [4:0]       day_r;
  logic [11:0]      year_r;
  logic [3:0]       y0_r;
  logic [3:0]       y1_r;
  logic [3:0]       y2_r;
  logic [3:0]       y3_r;

  logic [4:0]  a_val;
  logic [21:0] b_calc;
  logic [21:0] d_calc;
  logic [9:0]  f_calc;
  logic        wait_done;

  assign wait_done = (state_r == ST_WAIT) && div_rsp.done;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) state_nxt = (op_r == OP_Y3) ? ST_EMIT : ST_ISSUE;
      end
      ST_EMIT: begin
        if (pop && idx_r == LAST_IDX) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop         = (state_r == ST_IDLE) && !q_empty;
    empty         = (state_r != ST_EMIT);
    div_req.start = (state_r == ST_ISSUE);
    case (op_r)
      OP_A:    div_req.dividend = TS_W'({days_r, 2'b00}) + 32'd102032;
      OP_C:    div_req.dividend = TS_W'(b_r) * 32'd20 - 32'd2442;
      OP_E:    div_req.dividend = TS_W'(d_r) * 32'd1000;
      OP_G:    div_req.dividend = TS_W'(e_r) * 32'd601;
      OP_Y0:   div_req.dividend = TS_W'(year_r);
      default: div_req.dividend = num_r;
    endcase
    case (op_r)
      OP_SEC:  div_req.divisor = DV_MINUTE;
      OP_MIN:  div_req.divisor = DV_HOUR;
      OP_HR:   div_req.divisor = DV_DAY;
      OP_A:    div_req.divisor = DV_CENT;
      OP_C:    div_req.divisor = DV_YEAR;
      OP_E:    div_req.divisor = DV_MONTH;
      OP_G:    div_req.divisor = DV_MILLE;
      default: div_req.divisor = DV_DEC;
    endcase
  end

  // date arithmetic on the quotient just returned
  always_comb begin
    a_val  = 5'(div_rsp.quot) + 5'd15;
    b_calc = 22'(days_r) + 22'd2442113 + 22'(a_val) - 22'(a_val[4:2]);
    d_calc = b_r - 22'(div_rsp.quot[12:0]) * 22'd365 - 22'(div_rsp.quot[12:2]);
    f_calc = d_r - 10'(e_r) * 10'd30 - 10'(div_rsp.quot[9:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_SEC;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        op_r <= OP_SEC;
      end else if (wait_done) begin
        case (op_r)
          OP_SEC:  op_r <= OP_MIN;
          OP_MIN:  op_r <= OP_HR;
          OP_HR:   op_r <= OP_A;
          OP_A:    op_r <= OP_C;
          OP_C:    op_r <= OP_E;
          OP_E:    op_r <= OP_G;
          OP_G:    op_r <= OP_Y0;
          OP_Y0:   op_r <= OP_Y1;
          OP_Y1:   op_r <= OP_Y2;
          OP_Y2:   op_r <= OP_Y3;
          default: op_r <= OP_SEC;
        endcase
      end
      if (wait_done && op_r == OP_Y3) begin
        idx_r <= '0;
      end else if (state_r == ST_EMIT && pop) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      num_r <= q_data;
    end else if (wait_done) begin
      case (op_r)
        OP_SEC: begin
          sec_r <= 6'(div_rsp.rem);
          num_r <= div_rsp.quot;
        end
        OP_MIN: begin
          min_r <= 6'(div_rsp.rem);
          num_r <= div_rsp.quot;
        end
        OP_HR: begin
          hr_r   <= 5'(div_rsp.rem);
          days_r <= 16'(div_rsp.quot);
        end
        OP_A: b_r <= b_calc;
        OP_C: begin
          c_r <= 13'(div_rsp.quot);
          d_r <= 10'(d_calc);
        end
        OP_E: e_r <= 5'(div_rsp.quot);
        OP_G: begin
          day_r <= 5'(f_calc);
          // months past december belong to the next year
          if (e_r <= 5'd13) begin
            year_r <= 12'(c_r - 13'd4716);
            mon_r  <= 4'(e_r - 5'd1);
          end else begin
            year_r <= 12'(c_r - 13'd4715);
            mon_r  <= 4'(e_r - 5'd13);
          end
        end
        OP_Y0: begin
          y0_r  <= 4'(div_rsp.rem);
          num_r <= div_rsp.quot;
        end
        OP_Y1: begin
          y1_r  <= 4'(div_rsp.rem);
          num_r <= div_rsp.quot;
        end
        OP_Y2: begin
          y2_r  <= 4'(div_rsp.rem);
          num_r <= div_rsp.quot;
        end
        default: y3_r <= 4'(div_rsp.rem);
      endcase
    end
  end

  // character at the current line position
  always_comb begin
    case (idx_r)
      5'd0:    out_character = CH_U;
      5'd1:    out_character = CH_T;
      5'd2:    out_character = CH_C;
      5'd3:    out_character = CH_SPACE;
      5'd4:    out_character = digit_char(y3_r);
      5'd5:    out_character = digit_char(y2_r);
      5'd6:    out_character = digit_char(y1_r);
      5'd7:    out_character = digit_char(y0_r);
      5'd8:    out_character = CH_DASH;
      5'd9:    out_character = digit_char(tens_of(7'(mon_r)));
      5'd10:   out_character = digit_char(ones_of(7'(mon_r)));
      5'd11:   out_character = CH_DASH;
      5'd12:   out_character = digit_char(tens_of(7'(day_r)));
      5'd13:   out_character = digit_char(ones_of(7'(day_r)));
      5'd14:   out_character = CH_SPACE;
      5'd15:   out_character = digit_char(tens_of(7'(hr_r)));
      5'd16:   out_character = digit_char(ones_of(7'(hr_r)));
      5'd17:   out_character = CH_COLON;
      5'd18:   out_character = digit_char(tens_of(7'(min_r)));
      5'd19:   out_character = digit_char(ones_of(7'(min_r)));
      5'd20:   out_character = CH_COLON;
      5'd21:   out_character = digit_char(tens_of(7'(sec_r)));
      5'd22:   out_character = digit_char(ones_of(7'(sec_r)));
      default: out_character = CH_NL;
    endcase
  end

  assign out_last_char = (idx_r == LAST_IDX);

endmodule

// ----- hdl/ut2t_chk.sv -----
module ut2t_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_character,
  input logic       out_last_char
);
  import ut2t_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queue not clear after reset");

  a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_last_char |-> out_character == CH_NL)
    else $error("last word is not a newline");

  a_line_ends: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && pop && out_last_char |=> empty)
    else $error("word shown after end of line");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_character) && $stable(out_last_char))
    else $error("stalled word changed");

endmodule

bind unix_time_to_utc_text ut2t_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_character (out_character),
  .out_last_char (out_last_char)
);

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ut2t_pkg::*;

  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_CHANGED = 405;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } utc_char_t;

  logic              clk;
  logic              rst_n;
  logic              push;
  logic              full;
  logic [TS_W-1:0]   in_timestamp;
  logic              empty;
  logic              pop;
  logic [7:0]        out_character;
  logic              out_last_char;

  utc_char_t         pending_chars[$];
  logic [TS_W-1:0]   shadow_time;
  bit                no_gaps;
  int                err_count;
  int                stamps_sent;
  int                stamps_changed;
  int                words_checked;
  int                cycle_count;

  unix_time_to_utc_text u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_timestamp  (in_timestamp),
    .empty         (empty),
    .pop           (pop),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] dec_digit(input logic [31:0] v);
    return CH_ZERO + 8'(v % 10);
  endfunction

  // expected "UTC YYYY-MM-DD HH:MM:SS\n" for a changed sample
  function automatic void predict_utc_line(input logic [TS_W-1:0] ts);
    logic [31:0] t, sec, min, hr, a, b, c, d, e, f;
    logic [7:0]  text [LINE_LEN];
    if (ts == shadow_time) begin
      return;
    end
    shadow_time = ts;
    stamps_changed++;
    sec = ts % 60;
    t   = ts / 60;
    min = t % 60;
    t   = t / 60;
    hr  = t % 24;
    t   = t / 24;
    a = (4 * t + 102032) / 146097 + 15;
    b = t + 2442113 + a - (a / 4);
    c = (20 * b - 2442) / 7305;
    d = b - 365 * c - (c / 4);
    e = d * 1000 / 30601;
    f = d - e * 30 - e * 601 / 1000;
    if (e <= 13) begin
      c = c - 4716;
      e = e - 1;
    end else begin
      c = c - 4715;
      e = e - 13;
    end
    text = '{CH_U, CH_T, CH_C, CH_SPACE,
             dec_digit(c / 1000), dec_digit(c / 100), dec_digit(c / 10), dec_digit(c),
             CH_DASH, dec_digit(e / 10), dec_digit(e),
             CH_DASH, dec_digit(f / 10), dec_digit(f),
             CH_SPACE, dec_digit(hr / 10), dec_digit(hr),
             CH_COLON, dec_digit(min / 10), dec_digit(min),
             CH_COLON, dec_digit(sec / 10), dec_digit(sec), CH_NL};
    for (int k = 0; k < LINE_LEN; k++) begin
      pending_chars.push_back('{ch: text[k], last: (k == LINE_LEN - 1)});
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_stamp(input logic [TS_W-1:0] ts);
    push <= 1'b1;
    in_timestamp <= ts;
    do @(posedge clk); while (full);
    predict_utc_line(ts);
    stamps_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!no_gaps) begin
      if (r >= 92) begin
        n = $urandom_range(20, 400);
      end else if (r >= 55) begin
        n = $urandom_range(1, 4);
      end
    end
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic gap_and_send(input logic [TS_W-1:0] ts);
    idle_gap();
    send_stamp(ts);
  endtask

  // result side: stall pattern mixes short and long pop bursts, short stalls and long stalls
  initial begin
    int r, len;
    logic level;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        level = 1'b1;
        len = $urandom_range(1, 40);
      end else if (r < 55) begin
        level = 1'b1;
        len = $urandom_range(100, 300);
      end else if (r < 90) begin
        level = 1'b0;
        len = $urandom_range(1, 3);
      end else begin
        level = 1'b0;
        len = $urandom_range(20, 80);
      end
      pop <= level;
      repeat (len - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin : word_check
    utc_char_t want;
    if (rst_n && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected word: out_character 8'h%h, out_last_char %b",
               out_character, out_last_char);
        err_count++;
      end else begin
        want = pending_chars.pop_front();
        words_checked++;
        if (out_character !== want.ch) begin
          $error("out_character: expected 8'h%h, actual 8'h%h", want.ch, out_character);
          err_count++;
        end
        if (out_last_char !== want.last) begin
          $error("out_last_char: expected %b, actual %b", want.last, out_last_char);
          err_count++;
        end
      end
    end
  end

  // a zero right after reset matches the cleared sample, repeats are dropped
  task automatic test_zero_and_repeats();
    gap_and_send('0);
    gap_and_send('0);
    gap_and_send(32'd1);
    gap_and_send(32'd1);
    gap_and_send('0);
  endtask

  task automatic test_range_limits();
    gap_and_send(32'hFFFF_FFFF);
    gap_and_send(32'h7FFF_FFFF);
    gap_and_send(32'h8000_0000);
    gap_and_send(32'hAAAA_AAAA);
    gap_and_send(32'h5555_5555);
  endtask

  // year ends, leap days and the non-leap century
  task automatic test_calendar_edges();
    gap_and_send(32'd946684799);
    gap_and_send(32'd946684800);
    gap_and_send(32'd951782399);
    gap_and_send(32'd951868799);
    gap_and_send(32'd1230767999);
    gap_and_send(32'd1709164800);
    gap_and_send(32'd4107542399);
    gap_and_send(32'd4107542400);
  endtask

  task automatic test_random_stamps(input int changed_goal);
    int r, k, goal;
    logic [TS_W-1:0] ts, day_base;
    goal = stamps_changed + changed_goal;
    k = 0;
    while (stamps_changed < goal) begin
      if (k % 50 == 0) begin
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      k++;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        ts = $urandom();
      end else if (r < 75) begin
        // clock ticking forward
        ts = shadow_time + 32'($urandom_range(1, 3));
      end else if (r < 90) begin
        day_base = ($urandom() / 86400) * 86400;
        ts = day_base - 32'd1 + 32'($urandom_range(0, 2));
      end else begin
        ts = shadow_time;
      end
      gap_and_send(ts);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_timestamp = '0;
    shadow_time = '0;
    no_gaps = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_zero_and_repeats();
    test_range_limits();
    test_calendar_edges();
    test_random_stamps(RANDOM_CHANGED);

    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d timestamps (%0d changed, %0d repeated), %0d characters checked",
             stamps_sent, stamps_changed, stamps_sent - stamps_changed, words_checked);
    $display("covered full 32-bit range, leap days, century and year rollovers, stalls");
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
